[src/qte_pkg.sv]
`default_nettype none
package qte_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int TabLen = 24;
  localparam int CordicIters = (CORDIC_STEPS > TabLen) ? TabLen : CORDIC_STEPS;
  localparam int IterW = $clog2(TabLen);

  localparam int VecW = 40;
  localparam int SinW = 30;

  localparam logic [31:0] ATAN_TAB [TabLen] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721, 32'd20860,
    32'd10430, 32'd5215, 32'd2607, 32'd1303, 32'd651, 32'd325, 32'd162, 32'd81
  };

  typedef struct packed {
    logic signed [VecW-1:0] rn;
    logic signed [VecW-1:0] rd;
    logic signed [VecW-1:0] yn;
    logic signed [VecW-1:0] yd;
    logic signed [SinW-1:0] s;
    logic                   left;
  } qte_job_t;

  function automatic logic [15:0] to_out(input logic [31:0] acc);
    logic [31:0] r;
    r = acc + 32'h0000_8000;
    return r[31:16];
  endfunction

endpackage
`default_nettype wire

[src/quaternion_to_euler_angles.sv]
// channel | dir | tdata fields, lowest bit up
// s       | in  | quat_w[15:0] quat_x[31:16] quat_y[47:32] quat_z[63:48]
// m       | out | roll_angle[15:0] pitch_angle[31:16] yaw_angle[47:32] turning_left[48]
// The back limits throughput; it steps through accept, square, root setup, 29 square
// root steps, three CORDIC runs of one load plus 16 iterations, one output load.
// A zero vector or a full-scale pitch skips that run's iterations.
// The front has accept, multiply and push states; a two-entry job queue lets it take the next beat meanwhile.
// Async low reset clears the control state and the previous x.
// A stalled m side holds one result; the back waits only when it has a second.
`default_nettype none
module quaternion_to_euler_angles
  import qte_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [63:0] s_tdata_i,  // quat_w, quat_x, quat_y, quat_z
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [55:0]      m_tdata_o   // roll, pitch, yaw, turning_left, zero pad
);

  qte_job_t fj, bj;
  logic f_valid, f_ready, b_valid, b_ready;

  qte_front u_front (
    .clk_i, .rst_ni, .s_tvalid_i, .s_tready_o, .s_tdata_i,
    .job_valid_o(f_valid), .job_ready_i(f_ready), .job_o(fj)
  );

  qte_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(fj),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_data_o(bj)
  );

  qte_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(b_valid), .job_ready_o(b_ready), .job_i(bj),
    .m_tvalid_o, .m_tready_i, .m_tdata_o
  );

endmodule
`default_nettype wire

[src/qte_front.sv]
`default_nettype none
module qte_front
  import qte_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_tvalid_i,
  output logic                 s_tready_o,
  input  wire logic [63:0]     s_tdata_i,
  output logic                 job_valid_o,
  input  wire logic            job_ready_i,
  output qte_job_t             job_o
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0] st_q;
  logic signed [15:0] w_q, x_q, y_q, z_q, last_x_q;
  logic left_q;
  logic signed [31:0] p_wx_q, p_yz_q, p_xx_q, p_yy_q, p_wz_q, p_xy_q, p_wy_q, p_zx_q;
  logic signed [31:0] p_zz_q;

  logic signed [15:0] in_x;
  logic signed [VecW-1:0] sn;
  logic signed [VecW-1:0] one_q28;

  assign in_x = s_tdata_i[31:16];
  assign s_tready_o = (st_q == F_IDLE);
  assign job_valid_o = (st_q == F_PUSH);
  assign one_q28 = VecW'(1) <<< 28;

  always_comb begin
    sn = (VecW'(p_wy_q) - VecW'(p_zx_q)) <<< 1;
    job_o.rn = (VecW'(p_wx_q) + VecW'(p_yz_q)) <<< 1;
    job_o.rd = one_q28 - ((VecW'(p_xx_q) + VecW'(p_yy_q)) <<< 1);
    job_o.yn = (VecW'(p_wz_q) + VecW'(p_xy_q)) <<< 1;
    job_o.yd = one_q28 - ((VecW'(p_yy_q) + VecW'(p_zz_q)) <<< 1);
    if (sn > one_q28) job_o.s = SinW'(one_q28);
    else if (sn < -one_q28) job_o.s = SinW'(-one_q28);
    else job_o.s = SinW'(sn);
    job_o.left = left_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= F_IDLE;
      last_x_q <= '0;
    end else begin
      unique case (st_q)
        F_IDLE: begin
          if (s_tvalid_i) begin
            w_q <= s_tdata_i[15:0];
            x_q <= in_x;
            y_q <= s_tdata_i[47:32];
            z_q <= s_tdata_i[63:48];
            left_q <= (last_x_q < in_x);
            last_x_q <= in_x;
            st_q <= F_MUL;
          end
        end
        F_MUL: begin
          p_wx_q <= w_q * x_q;
          p_yz_q <= y_q * z_q;
          p_xx_q <= x_q * x_q;
          p_yy_q <= y_q * y_q;
          p_zz_q <= z_q * z_q;
          p_wz_q <= w_q * z_q;
          p_xy_q <= x_q * y_q;
          p_wy_q <= w_q * y_q;
          p_zx_q <= z_q * x_q;
          st_q <= F_PUSH;
        end
        F_PUSH: begin
          if (job_ready_i) st_q <= F_IDLE;
        end
        default: st_q <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[src/qte_fifo.sv]
`default_nettype none
module qte_fifo
  import qte_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     wr_valid_i,
  output logic          wr_ready_o,
  input  qte_job_t      wr_data_i,
  output logic          rd_valid_o,
  input  wire logic     rd_ready_i,
  output qte_job_t      rd_data_o
);

  qte_job_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic do_wr, do_rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o = mem_q[rp_q];
  assign do_wr = wr_valid_i && wr_ready_o;
  assign do_rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_wr) begin
        mem_q[wp_q] <= wr_data_i;
        wp_q <= ~wp_q;
      end
      if (do_rd) rp_q <= ~rp_q;
      if (do_wr && !do_rd) cnt_q <= cnt_q + 2'd1;
      else if (!do_wr && do_rd) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule
`default_nettype wire

[src/qte_back.sv]
`default_nettype none
module qte_back
  import qte_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        job_valid_i,
  output logic             job_ready_o,
  input  qte_job_t         job_i,
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [55:0]      m_tdata_o
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_SQ   = 3'd1;
  localparam logic [2:0] B_INIT = 3'd2;
  localparam logic [2:0] B_SQRT = 3'd3;
  localparam logic [2:0] B_LOAD = 3'd4;
  localparam logic [2:0] B_ITER = 3'd5;
  localparam logic [2:0] B_OUT  = 3'd6;

  localparam logic [1:0] J_ROLL  = 2'd0;
  localparam logic [1:0] J_PITCH = 2'd1;
  localparam logic [1:0] J_YAW   = 2'd2;

  logic [2:0] st_q;
  qte_job_t job_q;
  logic [28:0] sabs_q;
  logic [57:0] s2_q;
  logic [56:0] v_q;
  logic [57:0] res_q;
  logic [4:0] k_q;
  logic [1:0] sel_q;
  logic signed [VecW-1:0] cx_q, cy_q;
  logic [31:0] acc_q;
  logic [IterW-1:0] i_q;
  logic [15:0] roll_q, pitch_q, yaw_q;
  logic m_tvalid_q;
  logic [55:0] m_tdata_q;

  logic [57:0] bitv, trial;
  logic signed [VecW-1:0] op_y, op_x, xs, ys, nx, ny;
  logic [31:0] nacc;
  logic signed [15:0] pang;
  logic [15:0] pclamp;
  logic [28:0] cval;

  assign job_ready_o = (st_q == B_IDLE);
  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o = m_tdata_q;
  assign cval = res_q[28:0];

  always_comb begin
    bitv = 58'd1 << {k_q, 1'b0};
    trial = res_q + bitv;
    unique case (sel_q)
      J_ROLL: begin
        op_y = job_q.rn;
        op_x = job_q.rd;
      end
      J_PITCH: begin
        op_y = VecW'(job_q.s);
        op_x = VecW'({1'b0, cval});
      end
      default: begin
        op_y = job_q.yn;
        op_x = job_q.yd;
      end
    endcase
    xs = cx_q >>> i_q;
    ys = cy_q >>> i_q;
    if (cy_q > 0) begin
      nx = cx_q + ys;
      ny = cy_q - xs;
      nacc = acc_q + ATAN_TAB[i_q];
    end else begin
      nx = cx_q - ys;
      ny = cy_q + xs;
      nacc = acc_q - ATAN_TAB[i_q];
    end
    pang = to_out(nacc);
    if (pang > 16'sd16384) pclamp = 16'd16384;
    else if (pang < -16'sd16384) pclamp = 16'hC000;
    else pclamp = pang;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= B_IDLE;
      m_tvalid_q <= 1'b0;
    end else begin
      if (st_q == B_OUT && (!m_tvalid_q || m_tready_i)) m_tvalid_q <= 1'b1;
      else if (m_tready_i) m_tvalid_q <= 1'b0;
      unique case (st_q)
        B_IDLE: begin
          if (job_valid_i) begin
            job_q <= job_i;
            sabs_q <= job_i.s[SinW-1] ? 29'(-job_i.s) : 29'(job_i.s);
            st_q <= B_SQ;
          end
        end
        B_SQ: begin
          s2_q <= 58'(sabs_q) * 58'(sabs_q);
          st_q <= B_INIT;
        end
        B_INIT: begin
          v_q <= 57'((58'd1 << 56) - s2_q);
          res_q <= '0;
          k_q <= 5'd28;
          st_q <= B_SQRT;
        end
        B_SQRT: begin
          if ({1'b0, v_q} >= trial) begin
            v_q <= 57'({1'b0, v_q} - trial);
            res_q <= (res_q >> 1) + bitv;
          end else begin
            res_q <= res_q >> 1;
          end
          k_q <= k_q - 5'd1;
          if (k_q == 5'd0) begin
            sel_q <= J_ROLL;
            st_q <= B_LOAD;
          end
        end
        B_LOAD: begin
          if (sel_q == J_PITCH && cval == 29'd0) begin
            pitch_q <= job_q.s[SinW-1] ? 16'hC000 : 16'd16384;
            sel_q <= J_YAW;
          end else if (op_x == 0 && op_y == 0) begin
            unique case (sel_q)
              J_ROLL: roll_q <= '0;
              J_PITCH: pitch_q <= '0;
              default: yaw_q <= '0;
            endcase
            if (sel_q == J_YAW) st_q <= B_OUT;
            else sel_q <= sel_q + 2'd1;
          end else begin
            if (op_x < 0) begin
              cx_q <= -op_x;
              cy_q <= -op_y;
              acc_q <= 32'h8000_0000;
            end else begin
              cx_q <= op_x;
              cy_q <= op_y;
              acc_q <= '0;
            end
            i_q <= '0;
            st_q <= B_ITER;
          end
        end
        B_ITER: begin
          cx_q <= nx;
          cy_q <= ny;
          acc_q <= nacc;
          i_q <= i_q + IterW'(1);
          if (i_q == IterW'(CordicIters - 1)) begin
            unique case (sel_q)
              J_ROLL: roll_q <= to_out(nacc);
              J_PITCH: pitch_q <= pclamp;
              default: yaw_q <= to_out(nacc);
            endcase
            if (sel_q == J_YAW) st_q <= B_OUT;
            else begin
              sel_q <= sel_q + 2'd1;
              st_q <= B_LOAD;
            end
          end
        end
        B_OUT: begin
          if (!m_tvalid_q || m_tready_i) begin
            m_tdata_q <= {7'd0, job_q.left, yaw_q, pitch_q, roll_q};
            st_q <= B_IDLE;
          end
        end
        default: st_q <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
